// ===== rtl/core/selective_repeat_rx_tracker_core_assert.svh =====
// Assertion macros shared by the receive tracker RTL.
`ifndef SELECTIVE_REPEAT_RX_TRACKER_CORE_ASSERT_SVH
`define SELECTIVE_REPEAT_RX_TRACKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is active.
`define SRRT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define SRRT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/srrt_pkg.sv =====
// Types, constants and helper functions of the receive tracker.
package srrt_pkg;

  // Default configuration of the parameters.
  localparam int unsigned MAX_PACKETS_DEF  = 4096;
  localparam int unsigned RESEND_BURST_DEF = 64;
  localparam int unsigned CHUNK_BYTES_DEF  = 1436;

  // Header values that a data packet must carry.
  localparam logic [15:0] HDR_MAGIC   = 16'h5556;
  localparam logic [7:0]  HDR_VERSION = 8'd1;
  localparam logic [7:0]  TYPE_DATA   = 8'd1;

  // Field widths.
  localparam int unsigned ROW_BITS   = 64;
  localparam int unsigned XID_W      = 32;
  localparam int unsigned TOTAL_W    = 13;
  localparam int unsigned BASE_W     = 48;
  localparam int unsigned OFF_W      = 49;
  localparam int unsigned SEQ_OUT_W  = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 48;

  // Function codes of an input item.
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_DATA  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TRANSFER_ID   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_PACKETS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REMOTE_BASE   = 2'd2;

  // Result kinds.
  localparam logic MSG_ACK    = 1'b0;
  localparam logic MSG_RESEND = 1'b1;

  // Commands handed from the classifier to the executor.
  typedef enum logic [1:0] {
    OP_START    = 2'd0,
    OP_DATA     = 2'd1,
    OP_DATA_OOR = 2'd2,
    OP_TICK     = 2'd3
  } cmd_op_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] magic;
    logic [7:0]  version;
    logic [7:0]  pkt_type;
    logic [31:0] pkt_xid;
    logic [31:0] pkt_seq;
    logic [31:0] pkt_total;
  } in_item_t;

  typedef struct packed {
    logic                 msg_kind;
    logic [SEQ_OUT_W-1:0] seq_out;
    logic [OFF_W-1:0]     byte_offset;
    logic                 store_payload;
    logic                 done_res;
    logic                 last;
  } out_item_t;

  // Lowest set bit of a bitmap row: {found, index}.
  function automatic logic [6:0] first_set64(input logic [63:0] v);
    logic [6:0] res;
    res = '0;
    for (int i = 63; i >= 0; i--) begin
      if (v[i]) begin
        res = {1'b1, 6'(i)};
      end
    end
    return res;
  endfunction

  // Mask with the n lowest bits set, n from 0 to 64.
  function automatic logic [63:0] low_mask64(input logic [6:0] n);
    logic [63:0] m;
    if (n >= 7'd64) begin
      m = '1;
    end else begin
      m = (64'd1 << n) - 64'd1;
    end
    return m;
  endfunction

endpackage

// ===== rtl/core/selective_repeat_rx_tracker_core.sv =====
// Receive tracker for one selective-repeat transfer: top level.
// Input beats are classified at once and queued two deep; a start is handled in the idle state.
// A new data beat reads its bitmap row, sets its bit, walks the in-order count row by row, then acks.
// A tick scans rows from the in-order count and issues a resend request per missing packet, up to the burst size.
// The pace is set by the executor sequencer and the single read port of the bitmap RAM.
// Reset is asynchronous; it clears control state and per-row valid bits, no clearing pass.
`include "selective_repeat_rx_tracker_core_assert.svh"

module selective_repeat_rx_tracker_core #(
  parameter int unsigned MAX_PACKETS  = srrt_pkg::MAX_PACKETS_DEF,
  parameter int unsigned RESEND_BURST = srrt_pkg::RESEND_BURST_DEF,
  parameter int unsigned CHUNK_BYTES  = srrt_pkg::CHUNK_BYTES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [srrt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [srrt_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic                            push,
  input  srrt_pkg::in_item_t              item_i,
  output logic                            full,
  output logic                            empty,
  input  logic                            pop,
  output srrt_pkg::out_item_t             result_o
);

  import srrt_pkg::*;

  localparam int unsigned CNT_W   = $clog2(MAX_PACKETS + 1);
  localparam int unsigned IDX_W   = $clog2(MAX_PACKETS);
  localparam int unsigned CMD_W   = $bits(cmd_op_e) + IDX_W;
  localparam int unsigned RES_W   = $bits(out_item_t);

  // Configuration registers.
  logic [XID_W-1:0]   xid_q;
  logic [TOTAL_W-1:0] total_pk_q;
  logic [BASE_W-1:0]  base_q;
  logic [31:0]        tot32;
  logic [CNT_W-1:0]   eff_total;

  // Front to back command queue.
  logic             cmd_valid, cmd_push, cmd_full, cmd_empty, cmd_pop;
  cmd_op_e          cmd_op, cmd_head_op;
  logic [IDX_W-1:0] cmd_seq, cmd_head_seq;
  logic [CMD_W-1:0] cmd_head;

  // Back to output queue.
  logic       out_push, out_full, out_empty;
  out_item_t  out_item;
  logic [RES_W-1:0] res_head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xid_q      <= '0;
      total_pk_q <= TOTAL_W'(1);
      base_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_TRANSFER_ID:   xid_q      <= XID_W'(cfg_data_i);
        REG_TOTAL_PACKETS: total_pk_q <= TOTAL_W'(cfg_data_i);
        REG_REMOTE_BASE:   base_q     <= BASE_W'(cfg_data_i);
        default: begin
        end
      endcase
    end
  end

  // The total saturates at the bitmap size.
  assign tot32     = 32'(total_pk_q);
  assign eff_total = (tot32 > 32'(MAX_PACKETS)) ? CNT_W'(MAX_PACKETS) : CNT_W'(tot32);

  srrt_front #(
    .MAX_PACKETS(MAX_PACKETS)
  ) u_front (
    .item_i     (item_i),
    .xid_i      (xid_q),
    .total_i    (eff_total),
    .cmd_valid_o(cmd_valid),
    .cmd_op_o   (cmd_op),
    .cmd_seq_o  (cmd_seq)
  );

  // Every beat is taken while the command queue has room.
  assign full     = cmd_full;
  assign cmd_push = push && !cmd_full && cmd_valid;

  srrt_fifo #(
    .WIDTH(CMD_W),
    .DEPTH(2)
  ) u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .wdata_i({cmd_op, cmd_seq}),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .rdata_o(cmd_head),
    .empty_o(cmd_empty)
  );

  assign cmd_head_op  = cmd_op_e'(cmd_head[CMD_W-1 -: $bits(cmd_op_e)]);
  assign cmd_head_seq = cmd_head[IDX_W-1:0];

  srrt_back #(
    .MAX_PACKETS (MAX_PACKETS),
    .RESEND_BURST(RESEND_BURST),
    .CHUNK_BYTES (CHUNK_BYTES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(!cmd_empty),
    .cmd_op_i   (cmd_head_op),
    .cmd_seq_i  (cmd_head_seq),
    .cmd_pop_o  (cmd_pop),
    .total_i    (eff_total),
    .base_i     (base_q),
    .out_push_o (out_push),
    .out_item_o (out_item),
    .out_full_i (out_full)
  );

  // Results wait here until popped.
  srrt_fifo #(
    .WIDTH(RES_W),
    .DEPTH(2)
  ) u_out_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (out_push),
    .wdata_i(out_item),
    .full_o (out_full),
    .pop_i  (pop),
    .rdata_o(res_head),
    .empty_o(out_empty)
  );

  assign empty    = out_empty;
  assign result_o = out_item_t'(res_head);

  // Checks on the internal queues and result contents.
  `SRRT_ASSERT_IMP(a_out_no_overflow, clk_i, rst_ni, out_push, !out_full,
    "result pushed into a full output queue")
  `SRRT_ASSERT_NXT(a_cmd_lands, clk_i, rst_ni, cmd_push, !cmd_empty,
    "accepted command missing from the command queue")
  `SRRT_ASSERT_IMP(a_resend_clean, clk_i, rst_ni,
    out_push && (out_item.msg_kind == MSG_RESEND),
    !out_item.store_payload && !out_item.done_res,
    "resend request carries store or done")
  `SRRT_ASSERT_IMP(a_ack_last, clk_i, rst_ni,
    out_push && (out_item.msg_kind == MSG_ACK), out_item.last,
    "acknowledgement not marked last")

endmodule

// ===== rtl/core/srrt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module srrt_ram #(
  parameter int unsigned WIDTH = srrt_pkg::ROW_BITS,
  parameter int unsigned DEPTH = srrt_pkg::ROW_BITS,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/srrt_fifo.sv =====
// Small first-in first-out queue of register entries.
module srrt_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  // Pointer and fill-count update with wrap at the depth.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/core/srrt_front.sv =====
// Classifier: checks the header of an incoming beat and turns it into a command.
module srrt_front #(
  parameter int unsigned MAX_PACKETS = srrt_pkg::MAX_PACKETS_DEF,
  localparam int unsigned CNT_W = $clog2(MAX_PACKETS + 1),
  localparam int unsigned IDX_W = $clog2(MAX_PACKETS)
) (
  input  srrt_pkg::in_item_t  item_i,
  input  logic [31:0]         xid_i,
  input  logic [CNT_W-1:0]    total_i,
  output logic                cmd_valid_o,
  output srrt_pkg::cmd_op_e   cmd_op_o,
  output logic [IDX_W-1:0]    cmd_seq_o
);

  import srrt_pkg::*;

  logic hdr_ok;
  logic seq_in_range;

  // A data header must match the constants and the current transfer.
  assign hdr_ok = (item_i.magic == HDR_MAGIC) &&
                  (item_i.version == HDR_VERSION) &&
                  (item_i.pkt_type == TYPE_DATA) &&
                  (item_i.pkt_xid == xid_i) &&
                  (item_i.pkt_total == 32'(total_i));

  assign seq_in_range = (item_i.pkt_seq < 32'(total_i));
  assign cmd_seq_o    = IDX_W'(item_i.pkt_seq);

  // Dropped headers and the unused function code yield no command.
  always_comb begin
    cmd_valid_o = 1'b0;
    cmd_op_o    = OP_START;
    case (item_i.func)
      FUNC_START: begin
        cmd_valid_o = 1'b1;
        cmd_op_o    = OP_START;
      end
      FUNC_DATA: begin
        cmd_valid_o = hdr_ok;
        cmd_op_o    = seq_in_range ? OP_DATA : OP_DATA_OOR;
      end
      FUNC_TICK: begin
        cmd_valid_o = 1'b1;
        cmd_op_o    = OP_TICK;
      end
      default: begin
        cmd_valid_o = 1'b0;
      end
    endcase
  end

endmodule

// ===== rtl/core/srrt_back.sv =====
// Executor: keeps the received bitmap and in-order count and builds results.
module srrt_back #(
  parameter int unsigned MAX_PACKETS  = srrt_pkg::MAX_PACKETS_DEF,
  parameter int unsigned RESEND_BURST = srrt_pkg::RESEND_BURST_DEF,
  parameter int unsigned CHUNK_BYTES  = srrt_pkg::CHUNK_BYTES_DEF,
  localparam int unsigned CNT_W = $clog2(MAX_PACKETS + 1),
  localparam int unsigned IDX_W = $clog2(MAX_PACKETS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cmd_valid_i,
  input  srrt_pkg::cmd_op_e           cmd_op_i,
  input  logic [IDX_W-1:0]            cmd_seq_i,
  output logic                        cmd_pop_o,
  input  logic [CNT_W-1:0]            total_i,
  input  logic [srrt_pkg::BASE_W-1:0] base_i,
  output logic                        out_push_o,
  output srrt_pkg::out_item_t         out_item_o,
  input  logic                        out_full_i
);

  import srrt_pkg::*;

  localparam int unsigned ROWS   = (MAX_PACKETS + ROW_BITS - 1) / ROW_BITS;
  localparam int unsigned ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned N_W    = $clog2(RESEND_BURST + 1);
  localparam int unsigned CH_W   = $clog2(CHUNK_BYTES + 1);
  localparam int unsigned PROD_W = IDX_W + CH_W;

  // Sequencer states.
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_D_REQ  = 4'd1;
  localparam logic [3:0] S_D_CHK  = 4'd2;
  localparam logic [3:0] S_A_REQ  = 4'd3;
  localparam logic [3:0] S_A_CHK  = 4'd4;
  localparam logic [3:0] S_ACK    = 4'd5;
  localparam logic [3:0] S_T_REQ  = 4'd6;
  localparam logic [3:0] S_T_CHK  = 4'd7;
  localparam logic [3:0] S_T_LOAD = 4'd8;
  localparam logic [3:0] S_MUL    = 4'd9;
  localparam logic [3:0] S_PUSH   = 4'd10;

  // Control state.
  logic [3:0]       state_q, state_d;
  logic [3:0]       ret_q, ret_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             fin_q, fin_d;
  logic [ROWS-1:0]  rvalid_q, rvalid_d;
  logic             pend_v_q, pend_v_d;
  logic [N_W-1:0]   n_q, n_d;

  // Working registers.
  cmd_op_e              op_q, op_d;
  logic [IDX_W-1:0]     seq_q, seq_d;
  logic [CNT_W-1:0]     total_q, total_d;
  logic [BASE_W-1:0]    base_q, base_d;
  logic [CNT_W-1:0]     scan_q, scan_d;
  logic [IDX_W-1:0]     found_q, found_d;
  logic [IDX_W-1:0]     pend_q, pend_d;
  logic [ROW_W-1:0]     rd_row_q, rd_row_d;
  logic                 st_kind_q, st_kind_d;
  logic [SEQ_OUT_W-1:0] st_seq_out_q, st_seq_out_d;
  logic [IDX_W-1:0]     st_off_seq_q, st_off_seq_d;
  logic                 st_store_q, st_store_d;
  logic                 st_done_q, st_done_d;
  logic                 st_last_q, st_last_d;
  logic [PROD_W-1:0]    prod_q, prod_d;

  // Bitmap memory ports.
  logic                ram_we, ram_re;
  logic [ROW_W-1:0]    ram_waddr, ram_raddr;
  logic [ROW_BITS-1:0] ram_wdata, ram_rdata;

  // Helper values.
  logic [ROW_BITS-1:0] row_data;
  logic [31:0]         row_base32, tot32, seq32, cnt32, scan32;
  logic [31:0]         next32, lim32, hit32;
  logic [ROW_BITS-1:0] ones, miss, hi_mask;
  logic [6:0]          fz, fs;
  logic                fin_new;

  srrt_ram #(
    .WIDTH(ROW_BITS),
    .DEPTH(ROWS)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // A row never written since the last start reads as all zero.
  assign row_data   = rvalid_q[rd_row_q] ? ram_rdata : '0;
  assign row_base32 = 32'(rd_row_q) << 6;
  assign tot32      = 32'(total_q);
  assign seq32      = 32'(seq_q);
  assign cnt32      = 32'(count_q);
  assign scan32     = 32'(scan_q);

  // Advance search: first zero at or above the in-order position in this row.
  assign ones   = row_data | low_mask64({1'b0, cnt32[5:0]});
  assign fz     = first_set64(~ones);
  assign next32 = fz[6] ? row_base32 + 32'(fz[5:0]) : row_base32 + 32'(ROW_BITS);

  // Resend search: first missing bit from the scan position up to the total.
  assign lim32   = tot32 - row_base32;
  assign hi_mask = (lim32 >= 32'(ROW_BITS)) ? '1 : low_mask64(7'(lim32));
  assign miss    = ~row_data & ~low_mask64({1'b0, scan32[5:0]}) & hi_mask;
  assign fs      = first_set64(miss);
  assign hit32   = row_base32 + 32'(fs[5:0]);

  assign fin_new = fin_q || (count_q >= total_q);

  // Result beat toward the output queue.
  always_comb begin
    out_item_o.msg_kind      = st_kind_q;
    out_item_o.seq_out       = st_seq_out_q;
    out_item_o.byte_offset   = (st_kind_q == MSG_ACK && !st_store_q) ? '0 :
                               OFF_W'(base_q) + OFF_W'(prod_q);
    out_item_o.store_payload = st_store_q;
    out_item_o.done_res      = st_done_q;
    out_item_o.last          = st_last_q;
  end

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    ret_d        = ret_q;
    count_d      = count_q;
    fin_d        = fin_q;
    rvalid_d     = rvalid_q;
    pend_v_d     = pend_v_q;
    n_d          = n_q;
    op_d         = op_q;
    seq_d        = seq_q;
    total_d      = total_q;
    base_d       = base_q;
    scan_d       = scan_q;
    found_d      = found_q;
    pend_d       = pend_q;
    rd_row_d     = rd_row_q;
    st_kind_d    = st_kind_q;
    st_seq_out_d = st_seq_out_q;
    st_off_seq_d = st_off_seq_q;
    st_store_d   = st_store_q;
    st_done_d    = st_done_q;
    st_last_d    = st_last_q;
    prod_d       = prod_q;
    cmd_pop_o    = 1'b0;
    out_push_o   = 1'b0;
    ram_we       = 1'b0;
    ram_waddr    = rd_row_q;
    ram_wdata    = row_data | (64'd1 << seq32[5:0]);
    ram_re       = 1'b0;
    ram_raddr    = ROW_W'(seq32 >> 6);

    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          op_d      = cmd_op_i;
          seq_d     = cmd_seq_i;
          total_d   = total_i;
          base_d    = base_i;
          case (cmd_op_i)
            OP_START: begin
              rvalid_d = '0;
              count_d  = '0;
              fin_d    = 1'b0;
            end
            OP_DATA: begin
              state_d = S_D_REQ;
            end
            OP_DATA_OOR: begin
              state_d = S_ACK;
            end
            OP_TICK: begin
              if (!fin_q) begin
                scan_d   = count_q;
                n_d      = '0;
                pend_v_d = 1'b0;
                state_d  = S_T_REQ;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // Read the row that holds the packet's bit.
      S_D_REQ: begin
        ram_re    = 1'b1;
        ram_raddr = ROW_W'(seq32 >> 6);
        rd_row_d  = ROW_W'(seq32 >> 6);
        state_d   = S_D_CHK;
      end

      // A duplicate changes nothing; a new packet sets its bit.
      S_D_CHK: begin
        if (row_data[seq32[5:0]]) begin
          state_d = S_ACK;
        end else begin
          ram_we             = 1'b1;
          rvalid_d[rd_row_q] = 1'b1;
          state_d            = S_A_REQ;
        end
      end

      // Walk the in-order count over contiguous received rows.
      S_A_REQ: begin
        if (count_q >= total_q) begin
          state_d = S_ACK;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ROW_W'(cnt32 >> 6);
          rd_row_d  = ROW_W'(cnt32 >> 6);
          state_d   = S_A_CHK;
        end
      end

      S_A_CHK: begin
        if (next32 >= tot32) begin
          count_d = total_q;
          state_d = S_ACK;
        end else begin
          count_d = CNT_W'(next32);
          state_d = fz[6] ? S_ACK : S_A_REQ;
        end
      end

      // Build the acknowledgement.
      S_ACK: begin
        fin_d        = fin_new;
        st_kind_d    = MSG_ACK;
        st_seq_out_d = SEQ_OUT_W'(count_q);
        st_off_seq_d = seq_q;
        st_store_d   = (op_q == OP_DATA);
        st_done_d    = fin_new;
        st_last_d    = 1'b1;
        ret_d        = S_IDLE;
        state_d      = S_MUL;
      end

      // Resend scan: fetch the row at the scan position or finish.
      S_T_REQ: begin
        if (scan_q >= total_q) begin
          if (pend_v_q) begin
            st_kind_d    = MSG_RESEND;
            st_seq_out_d = SEQ_OUT_W'(pend_q);
            st_off_seq_d = pend_q;
            st_store_d   = 1'b0;
            st_done_d    = 1'b0;
            st_last_d    = 1'b1;
            pend_v_d     = 1'b0;
            ret_d        = S_IDLE;
            state_d      = S_MUL;
          end else begin
            state_d = S_IDLE;
          end
        end else begin
          ram_re    = 1'b1;
          ram_raddr = ROW_W'(scan32 >> 6);
          rd_row_d  = ROW_W'(scan32 >> 6);
          state_d   = S_T_CHK;
        end
      end

      // Find the next missing packet; the one held back goes out first.
      S_T_CHK: begin
        if (!fs[6]) begin
          scan_d  = ((row_base32 + 32'(ROW_BITS)) >= tot32) ? total_q :
                    CNT_W'(row_base32 + 32'(ROW_BITS));
          state_d = S_T_REQ;
        end else begin
          found_d = IDX_W'(hit32);
          scan_d  = CNT_W'(hit32 + 32'd1);
          if (pend_v_q) begin
            st_kind_d    = MSG_RESEND;
            st_seq_out_d = SEQ_OUT_W'(pend_q);
            st_off_seq_d = pend_q;
            st_store_d   = 1'b0;
            st_done_d    = 1'b0;
            st_last_d    = 1'b0;
            ret_d        = S_T_LOAD;
            state_d      = S_MUL;
          end else begin
            state_d = S_T_LOAD;
          end
        end
      end

      // Hold the found packet until the next one shows whether it is last.
      S_T_LOAD: begin
        pend_d   = found_q;
        pend_v_d = 1'b1;
        n_d      = n_q + 1'b1;
        if ((n_q + 1'b1) == N_W'(RESEND_BURST)) begin
          st_kind_d    = MSG_RESEND;
          st_seq_out_d = SEQ_OUT_W'(found_q);
          st_off_seq_d = found_q;
          st_store_d   = 1'b0;
          st_done_d    = 1'b0;
          st_last_d    = 1'b1;
          pend_v_d     = 1'b0;
          ret_d        = S_IDLE;
          state_d      = S_MUL;
        end else begin
          state_d = S_T_REQ;
        end
      end

      // Offset product, registered ahead of the base add.
      S_MUL: begin
        prod_d  = PROD_W'(st_off_seq_q) * PROD_W'(CHUNK_BYTES);
        state_d = S_PUSH;
      end

      S_PUSH: begin
        if (!out_full_i) begin
          out_push_o = 1'b1;
          state_d    = ret_q;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ret_q    <= S_IDLE;
      count_q  <= '0;
      fin_q    <= 1'b0;
      rvalid_q <= '0;
      pend_v_q <= 1'b0;
      n_q      <= '0;
    end else begin
      state_q  <= state_d;
      ret_q    <= ret_d;
      count_q  <= count_d;
      fin_q    <= fin_d;
      rvalid_q <= rvalid_d;
      pend_v_q <= pend_v_d;
      n_q      <= n_d;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    op_q         <= op_d;
    seq_q        <= seq_d;
    total_q      <= total_d;
    base_q       <= base_d;
    scan_q       <= scan_d;
    found_q      <= found_d;
    pend_q       <= pend_d;
    rd_row_q     <= rd_row_d;
    st_kind_q    <= st_kind_d;
    st_seq_out_q <= st_seq_out_d;
    st_off_seq_q <= st_off_seq_d;
    st_store_q   <= st_store_d;
    st_done_q    <= st_done_d;
    st_last_q    <= st_last_d;
    prod_q       <= prod_d;
  end

endmodule

// ===== verif/selective_repeat_rx_tracker_core_test.sv =====
// Self-checking testbench for the selective-repeat receive tracker core.
module selective_repeat_rx_tracker_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import srrt_pkg::*;

  localparam int unsigned MAP_DEPTH     = MAX_PACKETS_DEF;
  // Settling time allows for a full resend burst over a sparse map.
  localparam int unsigned SETTLE_CYCLES = 600;
  localparam int unsigned STALL_LIMIT   = 30000;
  localparam int unsigned LONG_HOLD     = 1500;
  localparam int unsigned MAX_REPORTS   = 40;
  localparam logic [1:0]  FUNC_SPARE    = 2'd3;

  logic                  clk_i      = 1'b0;
  logic                  rst_ni     = 1'b0;
  logic                  cfg_we_i   = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  push       = 1'b0;
  in_item_t              hdr_beat   = '0;
  logic                  full;
  logic                  empty;
  logic                  pop        = 1'b0;
  out_item_t             msg_beat;

  // Local copy of the transfer registers and the receive state.
  logic [31:0]          xid_cfg   = '0;
  logic [12:0]          total_cfg = 13'd1;
  logic [47:0]          base_cfg  = '0;
  bit [MAP_DEPTH-1:0]   rx_map    = '0;
  int unsigned          in_order  = 0;
  bit                   all_done  = 1'b0;

  in_item_t    hdr_backlog[$];
  out_item_t   due_msgs[$];
  bit          beat_taken   = 1'b0;
  bit          calm_tail    = 1'b0;
  bit          hold_req     = 1'b0;
  int unsigned gap_left     = 0;
  int unsigned stall_left   = 0;
  int unsigned hold_left    = 0;
  int unsigned quiet_cycles = 0;
  int unsigned n_items      = 0;
  int unsigned n_acks       = 0;
  int unsigned n_resends    = 0;
  int unsigned n_fail       = 0;

  selective_repeat_rx_tracker_core dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .push       (push),
    .item_i     (hdr_beat),
    .full       (full),
    .empty      (empty),
    .pop        (pop),
    .result_o   (msg_beat)
  );

  // 12 ns clock.
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Packet count after saturation at the map depth.
  function automatic int unsigned eff_total();
    return (total_cfg > 13'(MAP_DEPTH)) ? MAP_DEPTH : 32'(total_cfg);
  endfunction

  function automatic logic [OFF_W-1:0] chunk_offset(input int unsigned s);
    logic [63:0] sum;
    sum = 64'(base_cfg) + 64'(s) * 64'(CHUNK_BYTES_DEF);
    return sum[OFF_W-1:0];
  endfunction

  // Updates the receive state for one accepted beat and queues the messages it causes.
  task automatic track_beat(input in_item_t b);
    int unsigned lim;
    int unsigned s;
    int unsigned n;
    bit          have;
    out_item_t   m;
    out_item_t   held;
    lim  = eff_total();
    n    = 0;
    have = 1'b0;
    held = '0;
    if (b.func == FUNC_START) begin
      rx_map   = '0;
      in_order = 0;
      all_done = 1'b0;
    end else if (b.func == FUNC_DATA) begin
      if (b.magic == HDR_MAGIC && b.version == HDR_VERSION && b.pkt_type == TYPE_DATA &&
          b.pkt_xid == xid_cfg && b.pkt_total == lim) begin
        m          = '0;
        m.msg_kind = MSG_ACK;
        m.last     = 1'b1;
        // Out-of-range sequence numbers are acknowledged but not stored.
        if (b.pkt_seq < lim) begin
          m.store_payload = 1'b1;
          m.byte_offset   = chunk_offset(b.pkt_seq);
          if (!rx_map[b.pkt_seq]) begin
            rx_map[b.pkt_seq] = 1'b1;
            while (in_order < lim && rx_map[in_order]) in_order++;
          end
        end
        if (in_order >= lim) all_done = 1'b1;
        m.seq_out  = in_order[SEQ_OUT_W-1:0];
        m.done_res = all_done;
        due_msgs.push_back(m);
      end
    end else if (b.func == FUNC_TICK && !all_done) begin
      // Oldest missing packets first; the final one of the burst is marked last.
      for (s = in_order; s < lim && n < RESEND_BURST_DEF; s++) begin
        if (!rx_map[s]) begin
          if (have) due_msgs.push_back(held);
          held             = '0;
          held.msg_kind    = MSG_RESEND;
          held.seq_out     = s[SEQ_OUT_W-1:0];
          held.byte_offset = chunk_offset(s);
          have             = 1'b1;
          n++;
        end
      end
      if (have) begin
        held.last = 1'b1;
        due_msgs.push_back(held);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      n_fail++;
      if (n_fail <= MAX_REPORTS) begin
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      end
    end
  endtask

  // Compares one result beat with the oldest outstanding message.
  task automatic check_msg(input out_item_t got);
    out_item_t want;
    if (due_msgs.size() == 0) begin
      n_fail++;
      if (n_fail <= MAX_REPORTS) begin
        $display("%0t ns: unexpected result, expected none, actual %p", $time, got);
      end
    end else begin
      want = due_msgs.pop_front();
      check_field("msg_kind", want.msg_kind, got.msg_kind);
      check_field("seq_out", want.seq_out, got.seq_out);
      check_field("byte_offset", want.byte_offset, got.byte_offset);
      check_field("store_payload", want.store_payload, got.store_payload);
      check_field("done_res", want.done_res, got.done_res);
      check_field("last", want.last, got.last);
      if (want.msg_kind == MSG_ACK) n_acks++;
      else n_resends++;
    end
  endtask

  // Well-formed data header for the current transfer.
  function automatic in_item_t data_hdr(input logic [31:0] seq);
    in_item_t b;
    b.func      = FUNC_DATA;
    b.magic     = HDR_MAGIC;
    b.version   = HDR_VERSION;
    b.pkt_type  = TYPE_DATA;
    b.pkt_xid   = xid_cfg;
    b.pkt_seq   = seq;
    b.pkt_total = eff_total();
    return b;
  endfunction

  // Beat with the given function code and random header fields.
  function automatic in_item_t ctrl_beat(input logic [1:0] f);
    in_item_t b;
    b.func      = f;
    b.magic     = 16'($urandom());
    b.version   = 8'($urandom());
    b.pkt_type  = 8'($urandom());
    b.pkt_xid   = $urandom();
    b.pkt_seq   = $urandom();
    b.pkt_total = $urandom();
    return b;
  endfunction

  // Mostly valid data for the current transfer, with ticks, restarts and broken headers.
  function automatic in_item_t random_hdr();
    in_item_t    b;
    int unsigned lim;
    int unsigned win;
    int unsigned pick;
    lim  = eff_total();
    win  = (lim > 64 && $urandom_range(0, 1) == 0) ? 64 : lim;
    pick = $urandom_range(0, 99);
    b    = data_hdr((win == 0) ? 32'd0 : $urandom_range(0, win - 1));
    if (pick < 60) begin
      b = b;
    end else if (pick < 72) begin
      b = ctrl_beat(FUNC_TICK);
    end else if (pick < 76) begin
      b = ctrl_beat(FUNC_START);
    end else if (pick < 80) begin
      b = ctrl_beat(FUNC_SPARE);
    end else if (pick < 86) begin
      b.pkt_seq = (pick < 83) ? lim + $urandom_range(0, 3) : $urandom();
    end else begin
      case ($urandom_range(0, 4))
        0: b.magic = 16'($urandom());
        1: b.version = 8'($urandom());
        2: b.pkt_type = 8'($urandom());
        3: b.pkt_xid = b.pkt_xid ^ (32'd1 << $urandom_range(0, 31));
        default: b.pkt_total = b.pkt_total ^ (32'd1 << $urandom_range(0, 31));
      endcase
    end
    return b;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Writes all three transfer registers while the block is idle.
  task automatic program_transfer(input logic [31:0] xid, input logic [12:0] total,
                                  input logic [47:0] base);
    write_reg(REG_TRANSFER_ID, 48'(xid));
    write_reg(REG_TOTAL_PACKETS, 48'(total));
    write_reg(REG_REMOTE_BASE, base);
    xid_cfg   = xid;
    total_cfg = total;
    base_cfg  = base;
    @(posedge clk_i);
  endtask

  // Waits until every beat is sent and every message has come, then lets the core go idle.
  task automatic settle();
    while (hdr_backlog.size() != 0 || push || due_msgs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic add_random(input int unsigned count);
    repeat (count) hdr_backlog.push_back(random_hdr());
  endtask

  // Header driver: offers the next pending beat, with random gaps between beats.
  always @(negedge clk_i) begin
    if (rst_ni && (!push || beat_taken)) begin
      if (gap_left != 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (hdr_backlog.size() != 0) begin
        hdr_beat <= hdr_backlog.pop_front();
        push     <= 1'b1;
        if (!calm_tail && $urandom_range(0, 5) == 0) gap_left = $urandom_range(1, 10);
      end else begin
        push <= 1'b0;
      end
    end
    beat_taken = 1'b0;
  end

  // Result reader: random stalls, plus one long hold-off on request.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (hold_req) begin
      hold_req  = 1'b0;
      hold_left = LONG_HOLD - 1;
      pop <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
      if (!calm_tail && $urandom_range(0, 4) == 0) stall_left = $urandom_range(1, 10);
    end
  end

  // Monitor: checks result beats, tracks accepted header beats, and runs the watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      quiet_cycles++;
      if (pop && !empty) begin
        check_msg(msg_beat);
        quiet_cycles = 0;
      end
      if (push && !full) begin
        track_beat(hdr_beat);
        beat_taken   = 1'b1;
        n_items++;
        quiet_cycles = 0;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t ns: watchdog, no beat moved for %0d cycles", $time, STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    in_item_t b;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Five-packet transfer near the top of the offset range, driven by hand.
    program_transfer(32'hFFFF_FFFF, 13'd5, 48'hFFFF_FFFF_FFFF);
    hdr_backlog.push_back(ctrl_beat(FUNC_TICK));
    hdr_backlog.push_back(ctrl_beat(FUNC_START));
    b = data_hdr(0);
    b.magic = ~HDR_MAGIC;
    hdr_backlog.push_back(b);
    b = data_hdr(0);
    b.version = 8'hFE;
    hdr_backlog.push_back(b);
    b = data_hdr(0);
    b.pkt_type = 8'hFE;
    hdr_backlog.push_back(b);
    b = data_hdr(0);
    b.pkt_xid = 32'hFFFF_FFFE;
    hdr_backlog.push_back(b);
    b = data_hdr(0);
    b.pkt_total = 32'd6;
    hdr_backlog.push_back(b);
    // Out of order, then a duplicate, then the gap closes.
    hdr_backlog.push_back(data_hdr(2));
    hdr_backlog.push_back(data_hdr(0));
    hdr_backlog.push_back(data_hdr(0));
    hdr_backlog.push_back(data_hdr(1));
    hdr_backlog.push_back(ctrl_beat(FUNC_TICK));
    hdr_backlog.push_back(data_hdr(5));
    hdr_backlog.push_back(data_hdr(32'hFFFF_FFFF));
    hdr_backlog.push_back(data_hdr(4));
    hdr_backlog.push_back(data_hdr(3));
    // Data and a tick once the transfer is done, the unused code, a restart.
    hdr_backlog.push_back(data_hdr(1));
    hdr_backlog.push_back(ctrl_beat(FUNC_TICK));
    hdr_backlog.push_back(ctrl_beat(FUNC_SPARE));
    hdr_backlog.push_back(ctrl_beat(FUNC_START));
    hdr_backlog.push_back(ctrl_beat(FUNC_TICK));
    settle();

    // Zero-length transfer: the first accepted packet reports done.
    program_transfer(32'h0, 13'd0, 48'h0);
    hdr_backlog.push_back(ctrl_beat(FUNC_START));
    hdr_backlog.push_back(data_hdr(0));
    hdr_backlog.push_back(data_hdr(32'hFFFF_FFFF));
    hdr_backlog.push_back(ctrl_beat(FUNC_TICK));
    hdr_backlog.push_back(ctrl_beat(FUNC_START));
    hdr_backlog.push_back(ctrl_beat(FUNC_TICK));
    settle();

    // Transfer that may cross a bitmap row boundary.
    program_transfer($urandom(), 13'($urandom_range(20, 70)), 48'({$urandom(), $urandom()}));
    hdr_backlog.push_back(ctrl_beat(FUNC_START));
    add_random(20);
    settle();

    // Saturated packet count with a long reader hold-off, so the core backs up.
    program_transfer($urandom(), 13'h1FFF, 48'({$urandom(), $urandom()}));
    hold_req = 1'b1;
    hdr_backlog.push_back(ctrl_beat(FUNC_START));
    b = data_hdr(7);
    b.pkt_total = 32'h1FFF;
    hdr_backlog.push_back(b);
    repeat (6) hdr_backlog.push_back(ctrl_beat(FUNC_TICK));
    add_random(12);
    settle();

    // Largest exact transfer, touching the last sequence number.
    program_transfer($urandom(), 13'(MAP_DEPTH), 48'({$urandom(), $urandom()}));
    hdr_backlog.push_back(ctrl_beat(FUNC_START));
    hdr_backlog.push_back(data_hdr(MAP_DEPTH - 1));
    hdr_backlog.push_back(data_hdr(0));
    hdr_backlog.push_back(ctrl_beat(FUNC_TICK));
    add_random(16);
    settle();

    // Short transfers at full rate on both sides.
    calm_tail = 1'b1;
    program_transfer($urandom(), 13'($urandom_range(1, 16)), 48'({$urandom(), $urandom()}));
    hdr_backlog.push_back(ctrl_beat(FUNC_START));
    add_random(20);
    settle();

    $display("Run covered %0d header beats over six transfer setups, checking %0d acks",
             n_items, n_acks);
    $display("and %0d resend requests, including a long reader stall and a no-idle tail.",
             n_resends);
    if (n_fail == 0 && due_msgs.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/srrt_pkg.sv
rtl/core/srrt_ram.sv
rtl/core/srrt_fifo.sv
rtl/core/srrt_front.sv
rtl/core/srrt_back.sv
rtl/core/selective_repeat_rx_tracker_core.sv
verif/selective_repeat_rx_tracker_core_test.sv
